// ===== sv/cdq_pkg.sv =====
// Shared constants, codes and link types for the circular deque.
package cdq_pkg;

  // Storage geometry: one cell per element the deque can hold.
  localparam int DEPTH      = 128;
  localparam int DATA_W     = 32;
  localparam int OP_W       = 3;
  localparam int ERR_W      = 2;
  localparam int NUM_CELLS  = DEPTH - 1;

  // Rear select tree: cells are grouped, each group reduced in the first stage.
  localparam int SEL_GROUP  = 16;
  localparam int NUM_GROUPS = (NUM_CELLS + SEL_GROUP - 1) / SEL_GROUP;
  localparam int PAD_CELLS  = NUM_GROUPS * SEL_GROUP;

  // Request operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_ADD_REAR    = 3'd0,
    OP_ADD_FRONT   = 3'd1,
    OP_REMOVE_FRONT = 3'd2,
    OP_REMOVE_REAR = 3'd3,
    OP_PEEK_FRONT  = 3'd4,
    OP_PEEK_REAR   = 3'd5
  } op_t;

  // Result error codes.
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_POP_FRONT,
    CMD_PUSH_REAR,
    CMD_POP_REAR
  } cell_cmd_t;

  // Contents of one cell as seen by its neighbors.
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
  } slot_t;

  // Control bundle from the sequencer to the cells.
  typedef struct packed {
    cell_cmd_t         cmd;
    logic [DATA_W-1:0] data;
  } cell_ctl_t;

endpackage

// ===== sv/cdq_if.sv =====
// Request and result channel interfaces of the circular deque.
interface cdq_in_if;
  logic                            valid;
  logic                            ready;
  logic [cdq_pkg::OP_W-1:0]        operation;
  logic signed [cdq_pkg::DATA_W-1:0] value_in;

  modport source (output valid, output operation, output value_in, input ready);
  modport sink   (input valid, input operation, input value_in, output ready);
endinterface

interface cdq_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cdq_pkg::DATA_W-1:0] value_out;
  logic [cdq_pkg::ERR_W-1:0]         error_code;
  logic                              is_empty;
  logic                              is_full;

  modport source (output valid, output value_out, output error_code, output is_empty,
                  output is_full, input ready);
  modport sink   (input valid, input value_out, input error_code, input is_empty,
                  input is_full, output ready);
endinterface

// ===== sv/cdq_cell.sv =====
// One storage cell of the deque chain; shifts with its neighbors on command.
module cdq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  cdq_pkg::cell_ctl_t ctl,
  input  cdq_pkg::slot_t     left_i,
  input  cdq_pkg::slot_t     right_i,
  output cdq_pkg::slot_t     slot_o,
  output logic               tail_o
);

  logic                       valid_r;
  logic                       valid_nxt;
  logic [cdq_pkg::DATA_W-1:0] data_r;
  logic [cdq_pkg::DATA_W-1:0] data_nxt;

  // This cell holds the last element when its right neighbor is empty.
  assign tail_o = valid_r & ~right_i.valid;

  // Next contents depend on the command, the two neighbors and the cell's own contents.
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    case (ctl.cmd)
      cdq_pkg::CMD_PUSH_FRONT: begin
        valid_nxt = left_i.valid;
        data_nxt  = left_i.data;
      end
      cdq_pkg::CMD_POP_FRONT: begin
        valid_nxt = right_i.valid;
        data_nxt  = right_i.data;
      end
      cdq_pkg::CMD_PUSH_REAR: begin
        if (!valid_r && left_i.valid) begin
          valid_nxt = 1'b1;
          data_nxt  = ctl.data;
        end
      end
      cdq_pkg::CMD_POP_REAR: begin
        if (tail_o) begin
          valid_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Occupancy flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Element word.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign slot_o.valid = valid_r;
  assign slot_o.data  = data_r;

endmodule

// ===== sv/cdq_rear_sel.sv =====
// Two-stage registered select tree that picks the word of the tail cell.
module cdq_rear_sel (
  input  logic                                            clk,
  input  logic [cdq_pkg::NUM_CELLS-1:0]                   tail_i,
  input  cdq_pkg::slot_t [cdq_pkg::NUM_CELLS-1:0]         slots_i,
  output logic [cdq_pkg::DATA_W-1:0]                      rear_o
);

  logic [cdq_pkg::PAD_CELLS-1:0][cdq_pkg::DATA_W-1:0]  masked;
  logic [cdq_pkg::NUM_GROUPS-1:0][cdq_pkg::DATA_W-1:0] grp_nxt;
  logic [cdq_pkg::NUM_GROUPS-1:0][cdq_pkg::DATA_W-1:0] grp_r;
  logic [cdq_pkg::DATA_W-1:0]                          rear_nxt;
  logic [cdq_pkg::DATA_W-1:0]                          rear_r;

  // Only the tail cell passes its word; padding slots contribute zero.
  for (genvar i = 0; i < cdq_pkg::PAD_CELLS; i++) begin : g_mask
    if (i < cdq_pkg::NUM_CELLS) begin : g_real
      assign masked[i] = tail_i[i] ? slots_i[i].data : '0;
    end else begin : g_pad
      assign masked[i] = '0;
    end
  end

  // First stage: reduce each group of cells.
  always_comb begin
    for (int g = 0; g < cdq_pkg::NUM_GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < cdq_pkg::SEL_GROUP; k++) begin
        grp_nxt[g] = grp_nxt[g] | masked[g * cdq_pkg::SEL_GROUP + k];
      end
    end
  end

  // Second stage: reduce the group results.
  always_comb begin
    rear_nxt = '0;
    for (int g = 0; g < cdq_pkg::NUM_GROUPS; g++) begin
      rear_nxt = rear_nxt | grp_r[g];
    end
  end

  // Pipeline registers of the tree.
  always_ff @(posedge clk) begin
    grp_r  <= grp_nxt;
    rear_r <= rear_nxt;
  end

  assign rear_o = rear_r;

endmodule

// ===== sv/circular_deque.sv =====
// Circular deque: a chain of element cells with a request sequencer and result register.
// An accepted request moves the sequencer to ST_SETTLE_A, which sets the result valid.
// No new request is taken until ST_SETTLE_B returns the sequencer to ST_IDLE, so the
// two-stage rear select tree has settled on the new tail before the next request reads the rear.
// Reset clears the cell occupancy flags, the sequencer state and the result valid;
// the deque is empty and ready for a request in the first cycle after reset.
module circular_deque (
  input  logic       clk,
  input  logic       rst_n,
  cdq_in_if.sink     in_ch,
  cdq_out_if.source  out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETTLE_A,
    ST_SETTLE_B
  } state_t;

  state_t                                  state_r;
  logic                                    out_valid_r;
  logic [cdq_pkg::DATA_W-1:0]              out_value_r;
  cdq_pkg::err_t                           out_err_r;
  logic                                    out_empty_r;
  logic                                    out_full_r;

  cdq_pkg::slot_t [cdq_pkg::NUM_CELLS-1:0] slots;
  cdq_pkg::slot_t [cdq_pkg::NUM_CELLS-1:0] left_links;
  cdq_pkg::slot_t [cdq_pkg::NUM_CELLS-1:0] right_links;
  logic [cdq_pkg::NUM_CELLS-1:0]           tails;
  logic [cdq_pkg::DATA_W-1:0]              rear_data;
  cdq_pkg::cell_ctl_t                      ctl;
  cdq_pkg::cell_cmd_t                      req_cmd;
  cdq_pkg::err_t                           res_err;
  logic [cdq_pkg::DATA_W-1:0]              res_val;
  logic                                    in_fire;
  logic                                    is_empty_now;
  logic                                    is_full_now;

  // A new word is taken only when idle and the result slot is free or draining.
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Elements are packed from cell 0, so both flags sit at fixed cells.
  assign is_empty_now = ~slots[0].valid;
  assign is_full_now  = slots[cdq_pkg::NUM_CELLS-1].valid;

  // Decode the request against the present occupancy.
  always_comb begin
    req_cmd = cdq_pkg::CMD_HOLD;
    res_err = cdq_pkg::ERR_NONE;
    res_val = '0;
    case (cdq_pkg::op_t'(in_ch.operation))
      cdq_pkg::OP_ADD_REAR: begin
        if (is_full_now) res_err = cdq_pkg::ERR_FULL;
        else             req_cmd = cdq_pkg::CMD_PUSH_REAR;
      end
      cdq_pkg::OP_ADD_FRONT: begin
        if (is_full_now) res_err = cdq_pkg::ERR_FULL;
        else             req_cmd = cdq_pkg::CMD_PUSH_FRONT;
      end
      cdq_pkg::OP_REMOVE_FRONT: begin
        if (is_empty_now) begin
          res_err = cdq_pkg::ERR_EMPTY;
        end else begin
          req_cmd = cdq_pkg::CMD_POP_FRONT;
          res_val = slots[0].data;
        end
      end
      cdq_pkg::OP_REMOVE_REAR: begin
        if (is_empty_now) begin
          res_err = cdq_pkg::ERR_EMPTY;
        end else begin
          req_cmd = cdq_pkg::CMD_POP_REAR;
          res_val = rear_data;
        end
      end
      cdq_pkg::OP_PEEK_FRONT: begin
        if (is_empty_now) res_err = cdq_pkg::ERR_EMPTY;
        else              res_val = slots[0].data;
      end
      cdq_pkg::OP_PEEK_REAR: begin
        if (is_empty_now) res_err = cdq_pkg::ERR_EMPTY;
        else              res_val = rear_data;
      end
      default: begin
      end
    endcase
  end

  // The cells move only on an accepted word.
  assign ctl.cmd  = in_fire ? req_cmd : cdq_pkg::CMD_HOLD;
  assign ctl.data = in_ch.value_in;

  // Neighbor links; cell 0 sees the incoming word as an occupied left neighbor.
  for (genvar i = 0; i < cdq_pkg::NUM_CELLS; i++) begin : g_chain
    if (i == 0) begin : g_head
      assign left_links[i].valid = 1'b1;
      assign left_links[i].data  = in_ch.value_in;
    end else begin : g_body
      assign left_links[i] = slots[i-1];
    end
    if (i == cdq_pkg::NUM_CELLS - 1) begin : g_last
      assign right_links[i] = '0;
    end else begin : g_inner
      assign right_links[i] = slots[i+1];
    end

    cdq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .left_i  (left_links[i]),
      .right_i (right_links[i]),
      .slot_o  (slots[i]),
      .tail_o  (tails[i])
    );
  end

  // Rear word of the deque, registered through the group and final stages of the select tree.
  cdq_rear_sel u_rear_sel (
    .clk     (clk),
    .tail_i  (tails),
    .slots_i (slots),
    .rear_o  (rear_data)
  );

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            out_value_r <= res_val;
            out_err_r   <= res_err;
            state_r     <= ST_SETTLE_A;
          end
        end
        ST_SETTLE_A: begin
          out_valid_r <= 1'b1;
          out_empty_r <= is_empty_now;
          out_full_r  <= is_full_now;
          state_r     <= ST_SETTLE_B;
        end
        ST_SETTLE_B: begin
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value_out  = $signed(out_value_r);
  assign out_ch.error_code = out_err_r;
  assign out_ch.is_empty   = out_empty_r;
  assign out_ch.is_full    = out_full_r;

  // Every accepted word produces a result, set valid from ST_SETTLE_A.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> ##1 out_valid_r)
    else $error("accepted word did not produce a result");

  // Occupied cells stay packed from cell 0, so at most one tail exists.
  a_single_tail: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tails))
    else $error("cell chain has more than one tail");

  // A refused insert leaves the deque full.
  a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r == cdq_pkg::ERR_FULL) |-> out_full_r)
    else $error("full error reported while not full");

  // A refused read leaves the deque empty and returns zero.
  a_empty_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r == cdq_pkg::ERR_EMPTY) |-> (out_empty_r && out_value_r == '0))
    else $error("empty error reported with data or while occupied");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for circular_deque: directed and random requests against a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = cdq_pkg::DEPTH - 1;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_WAIT  = 10;
  localparam int RESET_CYCLES = 12;

  // Request codes that the block ignores.
  localparam logic [cdq_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [cdq_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [cdq_pkg::OP_W-1:0]          op;
    logic signed [cdq_pkg::DATA_W-1:0] value;
  } deque_request_t;

  typedef struct packed {
    logic signed [cdq_pkg::DATA_W-1:0] value;
    cdq_pkg::err_t                     err;
    logic                              empty;
    logic                              full;
  } deque_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cdq_in_if  in_ch ();
  cdq_out_if out_ch ();

  circular_deque dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Free-running clock, 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Pending request words and the replies the deque still owes.
  deque_request_t queued_requests[$];
  deque_reply_t   owed_replies[$];

  // Shadow copy of the deque contents and its two pointers.
  logic [cdq_pkg::DATA_W-1:0] shadow_store [cdq_pkg::DEPTH];
  int unsigned                head_slot = 0;
  int unsigned                tail_slot = 0;

  // Occupancy as planned by the stimulus generator.
  int plan_fill = 0;

  int  cycle_count    = 0;
  int  fail_count     = 0;
  int  replies_seen   = 0;
  int  full_refusals  = 0;
  int  empty_refusals = 0;
  int  times_full     = 0;
  int  request_gap    = 0;
  int  reply_stall    = 0;
  bit  calm_stretch   = 1'b0;
  logic request_taken = 1'b0;
  logic reply_taken   = 1'b0;

  function automatic int unsigned slot_next(int unsigned p);
    return (p == cdq_pkg::DEPTH - 1) ? 0 : p + 1;
  endfunction

  function automatic int unsigned slot_prev(int unsigned p);
    return (p == 0) ? cdq_pkg::DEPTH - 1 : p - 1;
  endfunction

  // Apply one request to the shadow deque and return the reply it must produce.
  function automatic deque_reply_t deque_apply(deque_request_t req);
    deque_reply_t rep;
    bit is_empty;
    bit is_full;
    rep.value = '0;
    rep.err   = cdq_pkg::ERR_NONE;
    is_empty  = (head_slot == tail_slot);
    is_full   = (slot_next(tail_slot) == head_slot);
    case (req.op)
      cdq_pkg::OP_ADD_REAR: begin
        if (is_full) begin
          rep.err = cdq_pkg::ERR_FULL;
        end else begin
          tail_slot = slot_next(tail_slot);
          shadow_store[tail_slot] = req.value;
        end
      end
      cdq_pkg::OP_ADD_FRONT: begin
        if (is_full) begin
          rep.err = cdq_pkg::ERR_FULL;
        end else begin
          shadow_store[head_slot] = req.value;
          head_slot = slot_prev(head_slot);
        end
      end
      cdq_pkg::OP_REMOVE_FRONT: begin
        if (is_empty) begin
          rep.err = cdq_pkg::ERR_EMPTY;
        end else begin
          head_slot = slot_next(head_slot);
          rep.value = shadow_store[head_slot];
        end
      end
      cdq_pkg::OP_REMOVE_REAR: begin
        if (is_empty) begin
          rep.err = cdq_pkg::ERR_EMPTY;
        end else begin
          rep.value = shadow_store[tail_slot];
          tail_slot = slot_prev(tail_slot);
        end
      end
      cdq_pkg::OP_PEEK_FRONT: begin
        if (is_empty) rep.err = cdq_pkg::ERR_EMPTY;
        else rep.value = shadow_store[slot_next(head_slot)];
      end
      cdq_pkg::OP_PEEK_REAR: begin
        if (is_empty) rep.err = cdq_pkg::ERR_EMPTY;
        else rep.value = shadow_store[tail_slot];
      end
      default: ;
    endcase
    rep.empty = (head_slot == tail_slot);
    rep.full  = (slot_next(tail_slot) == head_slot);
    return rep;
  endfunction

  // Idle length: mostly none or short, now and then long; none during a calm stretch.
  function automatic int draw_idle();
    int r;
    r = $urandom_range(0, 99);
    if (calm_stretch) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Element values lean on the extremes of the signed range.
  function automatic logic signed [cdq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // An add with the given percentage, otherwise a remove or a peek.
  function automatic logic [cdq_pkg::OP_W-1:0] pick_op(int add_pct);
    if ($urandom_range(0, 99) < add_pct) begin
      return $urandom_range(0, 1) ? cdq_pkg::OP_ADD_FRONT : cdq_pkg::OP_ADD_REAR;
    end
    case ($urandom_range(0, 5))
      0, 1: return cdq_pkg::OP_REMOVE_FRONT;
      2, 3: return cdq_pkg::OP_REMOVE_REAR;
      4: return cdq_pkg::OP_PEEK_FRONT;
      default: return cdq_pkg::OP_PEEK_REAR;
    endcase
  endfunction

  // Queue one request word and track the occupancy it leads to.
  task automatic queue_request(input logic [cdq_pkg::OP_W-1:0] op,
                               input logic signed [cdq_pkg::DATA_W-1:0] value);
    deque_request_t req;
    req.op    = op;
    req.value = value;
    queued_requests.push_back(req);
    case (op)
      cdq_pkg::OP_ADD_REAR, cdq_pkg::OP_ADD_FRONT: begin
        if (plan_fill < CAPACITY) plan_fill++;
      end
      cdq_pkg::OP_REMOVE_FRONT, cdq_pkg::OP_REMOVE_REAR: begin
        if (plan_fill > 0) plan_fill--;
      end
      default: ;
    endcase
  endtask

  // Request driver: holds a word until it is taken, then idles or offers the next one.
  always @(negedge clk) begin : request_driver
    deque_request_t item;
    logic drive_valid;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      drive_valid = in_ch.valid;
      if (!in_ch.valid || request_taken) begin
        if (request_gap > 0) begin
          request_gap--;
          drive_valid = 1'b0;
        end else if (queued_requests.size() > 0) begin
          item = queued_requests.pop_front();
          in_ch.operation <= item.op;
          in_ch.value_in  <= item.value;
          drive_valid = 1'b1;
          request_gap = draw_idle();
        end else begin
          drive_valid = 1'b0;
        end
      end
      in_ch.valid <= drive_valid;
    end
  end

  // Reply sink: stalls after some words and now and then while idle.
  always @(negedge clk) begin : reply_pacer
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (reply_taken || (reply_stall == 0 && $urandom_range(0, 19) == 0)) begin
        reply_stall = draw_idle();
      end
      if (reply_stall > 0) begin
        reply_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts each accepted request and checks each accepted reply.
  always @(posedge clk) begin : deque_monitor
    deque_request_t req;
    deque_reply_t   want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("circular_deque test failed");
      $finish;
    end else if (rst_n) begin
      request_taken <= in_ch.valid && in_ch.ready;
      reply_taken   <= out_ch.valid && out_ch.ready;

      if (in_ch.valid && in_ch.ready) begin
        req.op    = in_ch.operation;
        req.value = in_ch.value_in;
        want = deque_apply(req);
        owed_replies.push_back(want);
        if (want.err == cdq_pkg::ERR_FULL) full_refusals++;
        if (want.err == cdq_pkg::ERR_EMPTY) empty_refusals++;
        if (want.full && want.err == cdq_pkg::ERR_NONE &&
            (req.op == cdq_pkg::OP_ADD_REAR || req.op == cdq_pkg::OP_ADD_FRONT)) begin
          times_full++;
        end
        if ($urandom_range(0, 79) == 0) calm_stretch = !calm_stretch;
      end

      if (out_ch.valid && out_ch.ready) begin
        replies_seen++;
        if (owed_replies.size() == 0) begin
          $display("%0t: reply word with no request outstanding (value_out %0d)",
                   $time, out_ch.value_out);
          fail_count++;
        end else begin
          want = owed_replies.pop_front();
          if (out_ch.value_out !== want.value) begin
            $display("%0t: value_out expected %0d got %0d", $time, want.value,
                     out_ch.value_out);
            fail_count++;
          end
          if (out_ch.error_code !== want.err) begin
            $display("%0t: error_code expected %0d got %0d", $time, want.err,
                     out_ch.error_code);
            fail_count++;
          end
          if (out_ch.is_empty !== want.empty) begin
            $display("%0t: is_empty expected %0b got %0b", $time, want.empty,
                     out_ch.is_empty);
            fail_count++;
          end
          if (out_ch.is_full !== want.full) begin
            $display("%0t: is_full expected %0b got %0b", $time, want.full,
                     out_ch.is_full);
            fail_count++;
          end
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int planned;
    int phase;
    int spill;
    int burst;
    bit was_full;
    bit was_empty;
    logic [cdq_pkg::OP_W-1:0] op;

    in_ch.valid     = 1'b0;
    in_ch.operation = '0;
    in_ch.value_in  = '0;
    out_ch.ready    = 1'b0;

    // Directed: reads on an empty deque, ignored codes, extremes, pointer wrap at slot zero.
    queue_request(cdq_pkg::OP_PEEK_FRONT, 32'sd5);
    queue_request(cdq_pkg::OP_PEEK_REAR, -32'sd5);
    queue_request(cdq_pkg::OP_REMOVE_FRONT, '0);
    queue_request(cdq_pkg::OP_REMOVE_REAR, '0);
    queue_request(OP_SPARE_6, 32'sh1234_5678);
    queue_request(OP_SPARE_7, -1);
    queue_request(cdq_pkg::OP_ADD_REAR, 32'sh7FFF_FFFF);
    queue_request(cdq_pkg::OP_ADD_FRONT, 32'sh8000_0000);
    queue_request(cdq_pkg::OP_ADD_REAR, -1);
    queue_request(cdq_pkg::OP_ADD_FRONT, '0);
    queue_request(cdq_pkg::OP_PEEK_FRONT, '0);
    queue_request(cdq_pkg::OP_PEEK_REAR, '0);
    queue_request(OP_SPARE_7, '0);
    queue_request(cdq_pkg::OP_REMOVE_FRONT, '0);
    queue_request(cdq_pkg::OP_REMOVE_REAR, '0);
    queue_request(cdq_pkg::OP_REMOVE_FRONT, '0);
    queue_request(cdq_pkg::OP_REMOVE_REAR, '0);
    queue_request(cdq_pkg::OP_REMOVE_REAR, '0);
    queue_request(cdq_pkg::OP_ADD_FRONT, 32'sh5555_5555);
    queue_request(cdq_pkg::OP_REMOVE_REAR, '0);
    queue_request(cdq_pkg::OP_ADD_REAR, 32'shAAAA_AAAA);
    queue_request(cdq_pkg::OP_PEEK_FRONT, '0);
    queue_request(cdq_pkg::OP_REMOVE_FRONT, '0);

    // Random: fill to full and press on it, mix, drain to empty and press on it, mix.
    planned = 0;
    phase   = 0;
    while (planned < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin
          spill = $urandom_range(1, 4);
          while (spill > 0 && planned < RANDOM_ITEMS) begin
            op = pick_op(85);
            was_full = (plan_fill == CAPACITY);
            queue_request(op, pick_value());
            planned++;
            if (was_full && (op == cdq_pkg::OP_ADD_REAR || op == cdq_pkg::OP_ADD_FRONT)) begin
              spill--;
            end
          end
        end
        2: begin
          spill = $urandom_range(1, 4);
          while (spill > 0 && planned < RANDOM_ITEMS) begin
            op = pick_op(15);
            was_empty = (plan_fill == 0);
            queue_request(op, pick_value());
            planned++;
            if (was_empty && op != cdq_pkg::OP_ADD_REAR && op != cdq_pkg::OP_ADD_FRONT) begin
              spill--;
            end
          end
        end
        default: begin
          burst = $urandom_range(20, 60);
          repeat (burst) begin
            if ($urandom_range(0, 24) == 0) begin
              queue_request($urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6, pick_value());
            end else begin
              queue_request(pick_op(45), pick_value());
              planned++;
            end
          end
        end
      endcase
      phase++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every request to go in and every reply to come out; the request
    // side is looked at on the rising edge, where the driven signals are stable.
    while (queued_requests.size() != 0 || in_ch.valid) @(posedge clk);
    while (owed_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);

    $display("Checked %0d replies; the deque filled up %0d times, refused %0d adds when full",
             replies_seen, times_full, full_refusals);
    $display("and refused %0d reads when empty.", empty_refusals);
    if (fail_count == 0) begin
      $display("circular_deque test passed");
    end else begin
      $display("circular_deque test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cdq_pkg.sv
sv/cdq_if.sv
sv/cdq_cell.sv
sv/cdq_rear_sel.sv
sv/circular_deque.sv
sim/testbench.sv
